>>> src/dptcf_pkg.sv
// ----------------------------------------------------------------------------
// Drum pad trigger command framer package
// Shared types, register map, reset values and the frame byte function.
// ----------------------------------------------------------------------------
package dptcf_pkg;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;
  localparam int LEVEL_W    = 10;
  localparam int VOL_W      = 8;

  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_LEVEL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOFT_LIMIT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MEDIUM_LIMIT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SOFT_VOLUME   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MEDIUM_VOLUME = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LOUD_VOLUME   = 3'd5;

  localparam logic [LEVEL_W-1:0] RST_TRIGGER_LEVEL = 10'd100;
  localparam logic [LEVEL_W-1:0] RST_SOFT_LIMIT    = 10'd300;
  localparam logic [LEVEL_W-1:0] RST_MEDIUM_LIMIT  = 10'd600;
  localparam logic [VOL_W-1:0]   RST_SOFT_VOLUME   = 8'h14;
  localparam logic [VOL_W-1:0]   RST_MEDIUM_VOLUME = 8'h19;
  localparam logic [VOL_W-1:0]   RST_LOUD_VOLUME   = 8'h1E;

  // Pads, indexed as bass, snare, hi-hat.
  localparam int NUM_PADS = 3;
  localparam logic [1:0] PAD_BASS  = 2'd0;
  localparam logic [1:0] PAD_SNARE = 2'd1;
  localparam logic [1:0] PAD_HIHAT = 2'd2;

  localparam logic [7:0] TRACK_BASS  = 8'h03;
  localparam logic [7:0] TRACK_SNARE = 8'h01;
  localparam logic [7:0] TRACK_HIHAT = 8'h02;

  // Frame format.
  localparam logic [7:0] CMD_VOLUME  = 8'h06;
  localparam logic [7:0] CMD_PLAY    = 8'h03;
  localparam logic [7:0] BYTE_START  = 8'h7E;
  localparam logic [7:0] BYTE_VER    = 8'hFF;
  localparam logic [7:0] BYTE_LEN    = 8'h06;
  localparam logic [7:0] BYTE_ZERO   = 8'h00;
  localparam logic [7:0] BYTE_END    = 8'hEF;
  localparam logic [15:0] SUM_FIXED  = 16'h0105;

  localparam int BIDX_W = 4;
  localparam logic [BIDX_W-1:0] POS_START  = 4'd0;
  localparam logic [BIDX_W-1:0] POS_VER    = 4'd1;
  localparam logic [BIDX_W-1:0] POS_LEN    = 4'd2;
  localparam logic [BIDX_W-1:0] POS_CMD    = 4'd3;
  localparam logic [BIDX_W-1:0] POS_FEED   = 4'd4;
  localparam logic [BIDX_W-1:0] POS_P1     = 4'd5;
  localparam logic [BIDX_W-1:0] POS_P2     = 4'd6;
  localparam logic [BIDX_W-1:0] POS_CHK_HI = 4'd7;
  localparam logic [BIDX_W-1:0] POS_CHK_LO = 4'd8;
  localparam logic [BIDX_W-1:0] POS_END    = 4'd9;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SEND
  } dptcf_state_e;

  // Controller to datapath.
  typedef struct packed {
    logic              load;       // capture a sample set
    logic              emit;       // load the output register
    logic              play_frame; // 0: set-volume frame, 1: play-track frame
    logic [BIDX_W-1:0] byte_idx;
    logic              pad_done;   // retire the current pad
  } dptcf_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic pend_any;
    logic more_after;
    logic out_free;
  } dptcf_sts_t;

  // Byte at a given position of a frame with command cmd and parameter p2.
  function automatic logic [7:0] frame_byte_f(logic [7:0] cmd, logic [7:0] p2,
                                              logic [BIDX_W-1:0] idx);
    logic [15:0] sum;
    logic [15:0] chk;
    logic [7:0]  b;
    sum = SUM_FIXED + {8'h00, cmd} + {8'h00, p2};
    chk = 16'h0000 - sum;
    case (idx)
      POS_START:  b = BYTE_START;
      POS_VER:    b = BYTE_VER;
      POS_LEN:    b = BYTE_LEN;
      POS_CMD:    b = cmd;
      POS_FEED:   b = BYTE_ZERO;
      POS_P1:     b = BYTE_ZERO;
      POS_P2:     b = p2;
      POS_CHK_HI: b = chk[15:8];
      POS_CHK_LO: b = chk[7:0];
      POS_END:    b = BYTE_END;
      default:    b = BYTE_ZERO;
    endcase
    return b;
  endfunction

endpackage

>>> src/dptcf_if.sv
// ----------------------------------------------------------------------------
// Drum pad trigger command framer channel interfaces
// Valid/ready channels for sample sets and for outgoing frame bytes.
// ----------------------------------------------------------------------------
interface dptcf_in_if #(
  parameter int SAMPLE_BITS = 10
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] bass_sample;
  logic [SAMPLE_BITS-1:0] snare_sample;
  logic [SAMPLE_BITS-1:0] hihat_sample;

  modport source (output valid, output bass_sample, output snare_sample,
                  output hihat_sample, input ready);
  modport sink (input valid, input bass_sample, input snare_sample,
                input hihat_sample, output ready);
endinterface

interface dptcf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;
  logic       last_of_run;

  modport source (output valid, output frame_byte, output frame_end,
                  output last_of_run, input ready);
  modport sink (input valid, input frame_byte, input frame_end,
                input last_of_run, output ready);
endinterface

>>> src/drum_pad_trigger_command_framer.sv
// ----------------------------------------------------------------------------
// Drum pad trigger command framer
// Turns rising pad crossings into set-volume and play-track serial frames.
//
//   Channel    Dir  Carries                                   Handshake
//   sample_if  in   bass_sample, snare_sample, hihat_sample   valid/ready
//   frame_if   out  frame_byte, frame_end, last_of_run        valid/ready
//   cfg_*      in   cfg_idx_i, cfg_data_i                     cfg_we_i
//
// One sample set at a time: each triggered pad (0 to 3 pads) gets a
// set-volume and a play-track frame, one byte per cycle from the single
// output register while the sink is ready. A stalled sink holds the
// byte in the output register and pauses the byte counter. The next sample
// set is taken while the closing byte still waits. Reset clears the edge
// flags and loads the register defaults.
// ----------------------------------------------------------------------------
module drum_pad_trigger_command_framer
  import dptcf_pkg::*;
#(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  dptcf_in_if.sink              sample_if,
  dptcf_out_if.source           frame_if
);

  dptcf_cmd_t cmd;
  dptcf_sts_t sts;
  logic       in_ready;

  // Sequencer.
  dptcf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sample_if.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Registers, flags and frame builder.
  dptcf_dpath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .bass_sample_i  (sample_if.bass_sample),
    .snare_sample_i (sample_if.snare_sample),
    .hihat_sample_i (sample_if.hihat_sample),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (frame_if.valid),
    .out_ready_i    (frame_if.ready),
    .frame_byte_o   (frame_if.frame_byte),
    .frame_end_o    (frame_if.frame_end),
    .last_of_run_o  (frame_if.last_of_run)
  );

  assign sample_if.ready = in_ready;

endmodule

>>> src/dptcf_ctrl.sv
// ----------------------------------------------------------------------------
// Drum pad trigger command framer controller
// Sequences capture, pad scan and byte-by-byte frame emission.
// ----------------------------------------------------------------------------
module dptcf_ctrl
  import dptcf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dptcf_sts_t sts_i,
  output dptcf_cmd_t cmd_o
);

  dptcf_state_e      state_q, state_d;
  logic [BIDX_W-1:0] byte_idx_q, byte_idx_d;
  logic              play_q, play_d;

  // State and counter registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      byte_idx_q <= POS_START;
      play_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      byte_idx_q <= byte_idx_d;
      play_q     <= play_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d          = state_q;
    byte_idx_d       = byte_idx_q;
    play_d           = play_q;
    in_ready_o       = 1'b0;
    cmd_o            = '0;
    cmd_o.play_frame = play_q;
    cmd_o.byte_idx   = byte_idx_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        byte_idx_d = POS_START;
        play_d     = 1'b0;
        state_d    = sts_i.pend_any ? ST_SEND : ST_IDLE;
      end
      ST_SEND: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (byte_idx_q == POS_END) begin
            byte_idx_d = POS_START;
            if (play_q) begin
              // Both frames of this pad are out.
              play_d         = 1'b0;
              cmd_o.pad_done = 1'b1;
              state_d        = sts_i.more_after ? ST_SEND : ST_IDLE;
            end else begin
              play_d = 1'b1;
            end
          end else begin
            byte_idx_d = byte_idx_q + 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // A pad is being framed whenever bytes are sent.
  a_send_has_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SEND |-> sts_i.pend_any)
    else $error("sending with no pending pad");

  // The byte counter never leaves the frame.
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_idx_q <= POS_END)
    else $error("byte index beyond frame end");

endmodule

>>> src/dptcf_dpath.sv
// ----------------------------------------------------------------------------
// Drum pad trigger command framer datapath
// Configuration registers, edge flags, pending pads and the output register.
// ----------------------------------------------------------------------------
module dptcf_dpath
  import dptcf_pkg::*;
#(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic [SAMPLE_BITS-1:0] bass_sample_i,
  input  logic [SAMPLE_BITS-1:0] snare_sample_i,
  input  logic [SAMPLE_BITS-1:0] hihat_sample_i,
  input  dptcf_cmd_t             cmd_i,
  output dptcf_sts_t             sts_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [7:0]             frame_byte_o,
  output logic                   frame_end_o,
  output logic                   last_of_run_o
);

  localparam int CmpW = (SAMPLE_BITS > LEVEL_W) ? SAMPLE_BITS : LEVEL_W;

  logic [LEVEL_W-1:0] trig_lvl_q, soft_lim_q, med_lim_q;
  logic [VOL_W-1:0]   soft_vol_q, med_vol_q, loud_vol_q;

  logic [NUM_PADS-1:0] above_q;
  logic [NUM_PADS-1:0] pend_q;
  logic [VOL_W-1:0]    vol_q [NUM_PADS];

  logic [SAMPLE_BITS-1:0] samp   [NUM_PADS];
  logic [NUM_PADS-1:0]    above;
  logic [VOL_W-1:0]       vol    [NUM_PADS];
  logic [1:0]             cur_pad;
  logic [7:0]             track;
  logic [7:0]             cur_byte;
  logic                   is_last;

  logic             out_valid_q;
  logic [7:0]       out_byte_q;
  logic             out_end_q;
  logic             out_last_q;

  assign samp[PAD_BASS]  = bass_sample_i;
  assign samp[PAD_SNARE] = snare_sample_i;
  assign samp[PAD_HIHAT] = hihat_sample_i;

  // Configuration registers; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_lvl_q <= RST_TRIGGER_LEVEL;
      soft_lim_q <= RST_SOFT_LIMIT;
      med_lim_q  <= RST_MEDIUM_LIMIT;
      soft_vol_q <= RST_SOFT_VOLUME;
      med_vol_q  <= RST_MEDIUM_VOLUME;
      loud_vol_q <= RST_LOUD_VOLUME;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TRIGGER_LEVEL: trig_lvl_q <= cfg_data_i[LEVEL_W-1:0];
        REG_SOFT_LIMIT:    soft_lim_q <= cfg_data_i[LEVEL_W-1:0];
        REG_MEDIUM_LIMIT:  med_lim_q  <= cfg_data_i[LEVEL_W-1:0];
        REG_SOFT_VOLUME:   soft_vol_q <= cfg_data_i[VOL_W-1:0];
        REG_MEDIUM_VOLUME: med_vol_q  <= cfg_data_i[VOL_W-1:0];
        REG_LOUD_VOLUME:   loud_vol_q <= cfg_data_i[VOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Per-pad threshold test and volume band, evaluated on capture.
  always_comb begin
    for (int p = 0; p < NUM_PADS; p++) begin
      above[p] = CmpW'(samp[p]) > CmpW'(trig_lvl_q);
      if (CmpW'(samp[p]) < CmpW'(soft_lim_q)) begin
        vol[p] = soft_vol_q;
      end else if (CmpW'(samp[p]) < CmpW'(med_lim_q)) begin
        vol[p] = med_vol_q;
      end else begin
        vol[p] = loud_vol_q;
      end
    end
  end

  // Previous-above flags and pending triggers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      above_q <= '0;
      pend_q  <= '0;
    end else if (cmd_i.load) begin
      above_q <= above;
      pend_q  <= above & ~above_q;
    end else if (cmd_i.pad_done) begin
      pend_q[cur_pad] <= 1'b0;
    end
  end

  // Volume of each captured pad.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int p = 0; p < NUM_PADS; p++) begin
        vol_q[p] <= vol[p];
      end
    end
  end

  // Current pad in hi-hat, snare, bass order.
  always_comb begin
    if (pend_q[PAD_HIHAT]) begin
      cur_pad         = PAD_HIHAT;
      track           = TRACK_HIHAT;
      sts_o.more_after = pend_q[PAD_SNARE] | pend_q[PAD_BASS];
    end else if (pend_q[PAD_SNARE]) begin
      cur_pad         = PAD_SNARE;
      track           = TRACK_SNARE;
      sts_o.more_after = pend_q[PAD_BASS];
    end else begin
      cur_pad         = PAD_BASS;
      track           = TRACK_BASS;
      sts_o.more_after = 1'b0;
    end
    sts_o.pend_any = |pend_q;
    sts_o.out_free = !out_valid_q || out_ready_i;
  end

  // Byte builder.
  assign cur_byte = cmd_i.play_frame ? frame_byte_f(CMD_PLAY, track, cmd_i.byte_idx)
                                     : frame_byte_f(CMD_VOLUME, vol_q[cur_pad],
                                                    cmd_i.byte_idx);
  assign is_last  = cmd_i.play_frame && (cmd_i.byte_idx == POS_END) && !sts_o.more_after;

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_byte_q <= cur_byte;
      out_end_q  <= (cmd_i.byte_idx == POS_END);
      out_last_q <= is_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign frame_byte_o  = out_byte_q;
  assign frame_end_o   = out_end_q;
  assign last_of_run_o = out_last_q;

  // The closing byte of a run leaves no pad pending.
  a_last_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit && is_last |=> pend_q == '0)
    else $error("pads pending after last byte of run");

  // A new sample set is captured only once the previous one is drained.
  a_load_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> pend_q == '0)
    else $error("capture while pads still pending");

  // Emission never overwrites an untaken byte.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> sts_o.out_free)
    else $error("output register overrun");

endmodule
